>>> rtl/atfb_pkg.sv
// Shared types and constants of the transmit-request frame builder.
`timescale 1ns / 1ps
package atfb_pkg;

    // Frame constants
    localparam logic [7:0]  START_DELIM   = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE_TX = 8'h10;
    localparam logic [15:0] LEN_OVERHEAD  = 16'd14;
    localparam logic [7:0]  CSUM_BASE     = 8'hFF;

    // Configuration register reset values
    localparam logic [63:0] RST_DEST_WIDE  = 64'd0;
    localparam logic [15:0] RST_DEST_SHORT = 16'hFFFE;
    localparam logic [7:0]  RST_FRAME_ID   = 8'h01;
    localparam logic [7:0]  RST_RADIUS     = 8'h00;
    localparam logic [7:0]  RST_OPTIONS    = 8'h00;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_SHORT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS    = 3'd4;

    // Request type codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Byte positions of a start command
    localparam logic [4:0] STEP_DELIM    = 5'd0;
    localparam logic [4:0] STEP_LEN_HI   = 5'd1;
    localparam logic [4:0] STEP_LEN_LO   = 5'd2;
    localparam logic [4:0] STEP_TYPE     = 5'd3;
    localparam logic [4:0] STEP_ID       = 5'd4;
    localparam logic [4:0] STEP_WIDE_B7  = 5'd5;
    localparam logic [4:0] STEP_WIDE_B6  = 5'd6;
    localparam logic [4:0] STEP_WIDE_B5  = 5'd7;
    localparam logic [4:0] STEP_WIDE_B4  = 5'd8;
    localparam logic [4:0] STEP_WIDE_B3  = 5'd9;
    localparam logic [4:0] STEP_WIDE_B2  = 5'd10;
    localparam logic [4:0] STEP_WIDE_B1  = 5'd11;
    localparam logic [4:0] STEP_WIDE_B0  = 5'd12;
    localparam logic [4:0] STEP_SHORT_HI = 5'd13;
    localparam logic [4:0] STEP_SHORT_LO = 5'd14;
    localparam logic [4:0] STEP_RADIUS   = 5'd15;
    localparam logic [4:0] STEP_OPTIONS  = 5'd16;
    localparam logic [4:0] STEP_CSUM     = 5'd17;

    // Command queue
    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_AW    = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CW    = $clog2(CMD_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_STRAY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] flen;   // frame length field, start only
        logic [7:0]  data;   // payload byte, data only
        logic        close;  // checksum follows this command
    } t_cmd;

    typedef struct packed {
        logic [63:0] dest_wide;
        logic [15:0] dest_short;
        logic [7:0]  frame_id;
        logic [7:0]  radius;
        logic [7:0]  options;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
        logic       error;
    } t_res;

endpackage

>>> rtl/atfb_in_if.sv
// Request channel interface of the frame builder.
`timescale 1ns / 1ps
interface atfb_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;

    modport source (output valid, output req_type, output payload_len, output data_byte,
                    input ready);
    modport sink   (input valid, input req_type, input payload_len, input data_byte,
                    output ready);
endinterface

>>> rtl/atfb_out_if.sv
// Byte output channel interface of the frame builder.
`timescale 1ns / 1ps
interface atfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    logic       error;

    modport source (output valid, output out_byte, output frame_end, output run_last,
                    output error, input ready);
    modport sink   (input valid, input out_byte, input frame_end, input run_last,
                    input error, output ready);
endinterface

>>> rtl/api_tx_frame_builder.sv
// Top level of the API transmit-request frame builder.
//
// Channel   Dir  Modport  Payload
// i_req     in   sink     req_type, payload_len[15:0], data_byte[7:0]
// o_res     out  source   out_byte[7:0], frame_end, run_last, error
// i_cfg_*   in   -        write enable, 3-bit register index, 64-bit data
//
// One output byte per cycle unless stalled. A start transaction yields 17
// header bytes (18 with checksum for an empty payload), a payload
// transaction one or two. The byte sequencer and its output register set
// the rate; the front end takes a new request each cycle while the 4-entry
// command queue has room. Synchronous active-low reset clears frame state,
// queue and output valid, and loads the configuration defaults. A stalled
// output holds its byte while the front keeps filling the queue.
`timescale 1ns / 1ps
module api_tx_frame_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    atfb_in_if.sink                       i_req,
    atfb_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [atfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                   i_cfg_data
);
    import atfb_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_valid;

    // Configuration registers; the user writes only while idle (not enforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_wide  <= RST_DEST_WIDE;
            r_cfg.dest_short <= RST_DEST_SHORT;
            r_cfg.frame_id   <= RST_FRAME_ID;
            r_cfg.radius     <= RST_RADIUS;
            r_cfg.options    <= RST_OPTIONS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEST_WIDE:  r_cfg.dest_wide  <= i_cfg_data;
                CFG_DEST_SHORT: r_cfg.dest_short <= i_cfg_data[15:0];
                CFG_FRAME_ID:   r_cfg.frame_id   <= i_cfg_data[7:0];
                CFG_RADIUS:     r_cfg.radius     <= i_cfg_data[7:0];
                CFG_OPTIONS:    r_cfg.options    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front: classify requests, track open frame and remaining length
    atfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (front_cmd)
    );

    // Decoupling queue
    atfb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    // Back: byte sequencing, checksum, output register
    atfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res       (o_res)
    );

endmodule

>>> rtl/atfb_front.sv
// Request front end: accepts requests, tracks frame state, issues commands.
`timescale 1ns / 1ps
module atfb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    atfb_in_if.sink        i_req,
    input  logic           i_cmd_full,
    output logic           o_cmd_push,
    output atfb_pkg::t_cmd o_cmd
);
    import atfb_pkg::*;

    logic        r_open;
    logic [15:0] r_left;
    logic        n_open;
    logic [15:0] n_left;

    assign i_req.ready = !i_cmd_full;
    assign o_cmd_push  = i_req.valid && !i_cmd_full;

    always_comb begin
        o_cmd.kind  = CMD_STRAY;
        o_cmd.flen  = i_req.payload_len + LEN_OVERHEAD;
        o_cmd.data  = i_req.data_byte;
        o_cmd.close = 1'b0;
        n_open      = r_open;
        n_left      = r_left;
        if (i_req.req_type == REQ_START) begin
            o_cmd.kind  = CMD_START;
            o_cmd.close = (i_req.payload_len == 16'd0);
            n_open      = (i_req.payload_len != 16'd0);
            n_left      = i_req.payload_len;
        end else if (r_open) begin
            o_cmd.kind  = CMD_DATA;
            o_cmd.close = (r_left == 16'd1);
            n_open      = (r_left != 16'd1);
            n_left      = r_left - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 16'd0;
        end else if (o_cmd_push) begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

>>> rtl/atfb_cmd_fifo.sv
// Small command queue between front end and byte sequencer.
`timescale 1ns / 1ps
module atfb_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  atfb_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output atfb_pkg::t_cmd o_cmd
);
    import atfb_pkg::*;

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wr_ptr;
    logic [CMD_AW-1:0] r_rd_ptr;
    logic [CMD_CW-1:0] r_count;

    assign o_full  = (r_count == CMD_CW'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + CMD_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + CMD_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CMD_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CMD_CW'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMD_CW'(CMD_DEPTH))
        else $error("command queue count beyond depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("command queue popped while empty");
`endif

endmodule

>>> rtl/atfb_back.sv
// Byte sequencer: expands commands into frame bytes, keeps checksum.
`timescale 1ns / 1ps
module atfb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  atfb_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  atfb_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    atfb_out_if.source     o_res
);
    import atfb_pkg::*;

    logic [4:0] r_step;
    logic [7:0] r_sum;
    logic       r_out_valid;
    t_res       r_out;

    logic       advance;
    logic       is_last;
    logic       is_csum;
    logic       summed;
    logic [7:0] hdr_byte;
    t_res       res;
    logic [4:0] n_step;
    logic [7:0] n_sum;

    assign advance = i_cmd_valid && (!r_out_valid || o_res.ready);
    assign o_cmd_pop = advance && is_last;

    // Header byte for the current position of a start command
    always_comb begin
        case (r_step)
            STEP_DELIM:    hdr_byte = START_DELIM;
            STEP_LEN_HI:   hdr_byte = i_cmd.flen[15:8];
            STEP_LEN_LO:   hdr_byte = i_cmd.flen[7:0];
            STEP_TYPE:     hdr_byte = FRAME_TYPE_TX;
            STEP_ID:       hdr_byte = i_cfg.frame_id;
            STEP_WIDE_B7:  hdr_byte = i_cfg.dest_wide[63:56];
            STEP_WIDE_B6:  hdr_byte = i_cfg.dest_wide[55:48];
            STEP_WIDE_B5:  hdr_byte = i_cfg.dest_wide[47:40];
            STEP_WIDE_B4:  hdr_byte = i_cfg.dest_wide[39:32];
            STEP_WIDE_B3:  hdr_byte = i_cfg.dest_wide[31:24];
            STEP_WIDE_B2:  hdr_byte = i_cfg.dest_wide[23:16];
            STEP_WIDE_B1:  hdr_byte = i_cfg.dest_wide[15:8];
            STEP_WIDE_B0:  hdr_byte = i_cfg.dest_wide[7:0];
            STEP_SHORT_HI: hdr_byte = i_cfg.dest_short[15:8];
            STEP_SHORT_LO: hdr_byte = i_cfg.dest_short[7:0];
            STEP_RADIUS:   hdr_byte = i_cfg.radius;
            STEP_OPTIONS:  hdr_byte = i_cfg.options;
            default:       hdr_byte = CSUM_BASE - r_sum;
        endcase
    end

    always_comb begin
        res     = '0;
        is_last = 1'b1;
        is_csum = 1'b0;
        summed  = 1'b0;
        case (i_cmd.kind)
            CMD_START: begin
                res.out_byte = hdr_byte;
                is_csum      = (r_step == STEP_CSUM);
                summed       = (r_step >= STEP_TYPE) && (r_step <= STEP_OPTIONS);
                is_last      = is_csum || ((r_step == STEP_OPTIONS) && !i_cmd.close);
            end
            CMD_DATA: begin
                if (r_step == STEP_DELIM) begin
                    res.out_byte = i_cmd.data;
                    summed       = 1'b1;
                    is_last      = !i_cmd.close;
                end else begin
                    res.out_byte = CSUM_BASE - r_sum;
                    is_csum      = 1'b1;
                end
            end
            default: begin
                res.error = 1'b1;
            end
        endcase
        res.frame_end = is_csum;
        res.run_last  = is_last;
    end

    always_comb begin
        n_step = is_last ? 5'd0 : r_step + 5'd1;
        n_sum  = r_sum;
        if (is_csum || (i_cmd.kind == CMD_START && r_step == STEP_DELIM)) begin
            n_sum = 8'd0;
        end else if (summed) begin
            n_sum = r_sum + res.out_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 5'd0;
            r_sum       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step      <= n_step;
                r_sum       <= n_sum;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_byte  = r_out.out_byte;
    assign o_res.frame_end = r_out.frame_end;
    assign o_res.run_last  = r_out.run_last;
    assign o_res.error     = r_out.error;

`ifndef SYNTH
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> r_out.run_last)
        else $error("checksum byte not marked last");
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error) |-> (r_out.run_last && !r_out.frame_end))
        else $error("error result malformed");
`endif

endmodule

>>> tb/api_tx_frame_builder_tb.sv
// Self-checking testbench of the API transmit-request frame builder.
`timescale 1ns / 1ps
module api_tx_frame_builder_tb;
    import atfb_pkg::*;

    // No acceptance on either channel for this many cycles ends the run.
    localparam int unsigned IDLE_LIMIT = 2000;
    // Cycles to let pass after the last expected byte before a register write or the end.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_PRINTS = 40;
    localparam int unsigned RAND_PHASES = 5;
    localparam int unsigned PHASE_ITEMS = 46;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,      // always ready
        RX_MOSTLY,    // ready at random, with probability three in four
        RX_SPARSE,    // ready at random, with probability one in four
        RX_PERIODIC   // fixed stall stripes
    } t_rx_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [63:0]      i_cfg_data;

    atfb_in_if  req_if ();
    atfb_out_if res_if ();

    api_tx_frame_builder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Frame builder model: register copy, frame state and the bytes it
    // predicts, oldest first.
    // ------------------------------------------------------------------
    t_cfg        cfg_model;
    logic [15:0] bytes_left;
    logic [7:0]  csum_acc;
    logic        frame_open;
    t_res        exp_bytes[$];

    // Run statistics
    int unsigned err_count;
    int unsigned items_sent;
    int unsigned frames_closed;
    int unsigned stray_count;
    int unsigned restart_count;
    int unsigned setting_count;
    int unsigned bytes_checked;

    // Sender burst state
    int unsigned burst_left;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Mismatch report: one line per mismatch, printing capped.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_count < MAX_PRINTS)
            $display("[%0t] mismatch %s: got 0x%0h want 0x%0h (byte %0d)",
                     $time, what, got, want, bytes_checked);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic summed, input logic fin,
                             input logic last, input logic err);
        t_res r;
        if (summed)
            csum_acc = csum_acc + b;
        r.out_byte  = b;
        r.frame_end = fin;
        r.run_last  = last;
        r.error     = err;
        exp_bytes.push_back(r);
    endtask

    // Checksum byte ends the frame and clears the running sum.
    task automatic close_frame();
        push_byte(CSUM_BASE - csum_acc, 1'b0, 1'b1, 1'b1, 1'b0);
        frame_open = 1'b0;
        csum_acc   = 8'h00;
        frames_closed++;
    endtask

    // Expected bytes of one accepted request transaction.
    task automatic predict_frame_bytes(input logic kind, input logic [15:0] plen,
                                       input logic [7:0] dbyte);
        logic [15:0] flen;
        int i;
        if (kind == REQ_START) begin
            if (frame_open)
                restart_count++;   // open frame dropped without checksum
            csum_acc = 8'h00;
            flen = plen + LEN_OVERHEAD;   // wraps for lengths above 65521
            push_byte(START_DELIM, 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(flen[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(flen[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(FRAME_TYPE_TX, 1'b1, 1'b0, 1'b0, 1'b0);
            push_byte(cfg_model.frame_id, 1'b1, 1'b0, 1'b0, 1'b0);
            for (i = 7; i >= 0; i--)
                push_byte(cfg_model.dest_wide[8*i +: 8], 1'b1, 1'b0, 1'b0, 1'b0);
            push_byte(cfg_model.dest_short[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
            push_byte(cfg_model.dest_short[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
            push_byte(cfg_model.radius, 1'b1, 1'b0, 1'b0, 1'b0);
            push_byte(cfg_model.options, 1'b1, 1'b0, plen != 16'd0, 1'b0);
            bytes_left = plen;
            if (plen == 16'd0)
                close_frame();     // empty payload: checksum right after header
            else
                frame_open = 1'b1;
        end else if (!frame_open) begin
            // Payload byte outside a frame: error byte, state untouched
            stray_count++;
            push_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
            bytes_left = bytes_left - 16'd1;
            push_byte(dbyte, 1'b1, 1'b0, bytes_left != 16'd0, 1'b0);
            if (bytes_left == 16'd0)
                close_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Called at
    // a rising edge; returns at the edge where the transaction is accepted.
    // ------------------------------------------------------------------
    task automatic send_req(input logic kind, input logic [15:0] plen,
                            input logic [7:0] dbyte);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.payload_len <= plen;
        req_if.data_byte   <= dbyte;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_frame_bytes(kind, plen, dbyte);
        items_sent++;
    endtask

    // Byte with extra weight on both ends of the range.
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Start transaction; the unused data field carries noise.
    task automatic send_start(input logic [15:0] plen);
        send_req(REQ_START, plen, 8'($urandom_range(0, 255)));
    endtask

    // Payload transaction; the unused length field carries noise.
    task automatic send_data(input logic [7:0] dbyte);
        send_req(REQ_DATA, 16'($urandom_range(0, 65535)), dbyte);
    endtask

    // Wait for every expected byte, then let the pipeline settle.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (exp_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all five registers on consecutive edges; block must be idle.
    task automatic apply_setting(input t_cfg s);
        logic [63:0] vals [5];
        logic [CFG_IDX_W-1:0] idxs [5];
        int k;
        idxs[0] = CFG_DEST_WIDE;  vals[0] = s.dest_wide;
        idxs[1] = CFG_DEST_SHORT; vals[1] = {48'd0, s.dest_short};
        idxs[2] = CFG_FRAME_ID;   vals[2] = {56'd0, s.frame_id};
        idxs[3] = CFG_RADIUS;     vals[3] = {56'd0, s.radius};
        idxs[4] = CFG_OPTIONS;    vals[4] = {56'd0, s.options};
        for (k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_model = s;
        setting_count++;
        @(posedge i_clk);
    endtask

    function automatic t_cfg rand_cfg();
        t_cfg s;
        s.dest_wide  = {$urandom, $urandom};
        s.dest_short = 16'($urandom_range(0, 65535));
        s.frame_id   = pick_byte();
        s.radius     = pick_byte();
        s.options    = pick_byte();
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Header with reset defaults, empty and one-byte payloads.
    task automatic test_reset_header();
        send_start(16'd0);
        send_start(16'd1);
        send_data(8'h00);
    endtask

    // All-ones and all-zeros register settings.
    task automatic test_register_extremes();
        drain();
        apply_setting('1);
        send_start(16'd0);
        send_start(16'd2);
        send_data(8'hFF);
        send_data(8'h00);
        drain();
        apply_setting('0);
        send_start(16'd0);
    endtask

    // Payload bytes with no frame open.
    task automatic test_stray_bytes();
        send_data(8'hFF);
        send_data(8'h00);
    endtask

    // A new start abandons the open frame.
    task automatic test_frame_restart();
        send_start(16'd3);
        send_data(8'hA5);
        send_data(8'h5A);
        send_start(16'd1);
        send_data(8'h3C);
    endtask

    // Largest legal length, then lengths whose length field wraps, then an empty frame.
    task automatic test_length_extremes();
        send_start(16'd65521);
        send_data(8'h01);
        send_data(8'hFE);
        send_start(16'hFFFF);
        send_data(8'h80);
        send_start(16'd65522);
        send_start(16'd0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed frames with random content, plus
    // stray bytes, truncated frames and starts with wide random lengths.
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        int unsigned p;
        int unsigned phase_start;
        int unsigned r;
        int unsigned len;
        int unsigned cut;
        int unsigned k;
        for (p = 0; p < RAND_PHASES; p++) begin
            drain();
            if (p == 1)
                apply_setting('1);
            else if (p == 3)
                apply_setting('0);
            else
                apply_setting(rand_cfg());
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_data(pick_byte());
                end else if (r < 15) begin
                    // Long frame left open; the next start drops it
                    send_start(16'($urandom_range(0, 65535)));
                    for (k = 0; k < $urandom_range(0, 3); k++)
                        send_data(pick_byte());
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
                    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
                    send_start(16'(len));
                    for (k = 0; k < cut; k++)
                        send_data(pick_byte());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows a stall pattern that changes at random.
    // ------------------------------------------------------------------
    initial begin : rx_stall
        t_rx_mode mode;
        int unsigned hold;
        res_if.ready <= 1'b0;
        mode = RX_OPEN;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                hold = $urandom_range(16, 96);
            end
            hold--;
            case (mode)
                RX_OPEN:   res_if.ready <= 1'b1;
                RX_MOSTLY: res_if.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                default:   res_if.ready <= ((hold % 9) > 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted byte against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_check
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (exp_bytes.size() == 0) begin
                report_mismatch("unexpected byte", res_if.out_byte, 0);
            end else begin
                want = exp_bytes.pop_front();
                if (res_if.out_byte !== want.out_byte)
                    report_mismatch("out_byte", res_if.out_byte, want.out_byte);
                if (res_if.frame_end !== want.frame_end)
                    report_mismatch("frame_end", res_if.frame_end, want.frame_end);
                if (res_if.run_last !== want.run_last)
                    report_mismatch("run_last", res_if.run_last, want.run_last);
                if (res_if.error !== want.error)
                    report_mismatch("error", res_if.error, want.error);
            end
            bytes_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any transaction on either channel.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] watchdog: no transaction for %0d cycles, %0d bytes pending",
                 $time, IDLE_LIMIT, exp_bytes.size());
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Known input values from time zero
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_DEST_WIDE;
        i_cfg_data         <= 64'd0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_START;
        req_if.payload_len <= 16'd0;
        req_if.data_byte   <= 8'd0;

        // Model state after reset
        cfg_model.dest_wide  = RST_DEST_WIDE;
        cfg_model.dest_short = RST_DEST_SHORT;
        cfg_model.frame_id   = RST_FRAME_ID;
        cfg_model.radius     = RST_RADIUS;
        cfg_model.options    = RST_OPTIONS;
        bytes_left    = 16'd0;
        csum_acc      = 8'h00;
        frame_open    = 1'b0;
        err_count     = 0;
        items_sent    = 0;
        frames_closed = 0;
        stray_count   = 0;
        restart_count = 0;
        setting_count = 0;
        bytes_checked = 0;
        burst_left    = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_header();
        test_register_extremes();
        test_stray_bytes();
        test_frame_restart();
        test_length_extremes();
        test_random_traffic();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (exp_bytes.size() != 0)
            report_mismatch("bytes left over", exp_bytes.size(), 0);

        $display("Sent %0d requests under %0d register settings; checked %0d output bytes.",
                 items_sent, setting_count, bytes_checked);
        $display("Frames closed %0d, stray payload bytes %0d, abandoned frames %0d, errors %0d.",
                 frames_closed, stray_count, restart_count, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
